// ===== rtl/core/mvt_pkg.sv =====
// Shared types and constants for the 4x4 matrix-vector transform core.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package mvt_pkg;

	// Field width of every element and vector component on the ports
	localparam int FIELD_W = 32;
	// Matrix geometry: 4x4 elements, column-major, index = col * 4 + row
	localparam int LANES     = 4;
	localparam int MAT_DEPTH = 16;
	localparam int IDX_W     = 4;

	// Item command codes
	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_XFORM = 1'b1
	} cmd_t;

	// One input item
	typedef struct packed {
		cmd_t                      cmd;
		logic        [IDX_W-1:0]   elem_index;
		logic signed [FIELD_W-1:0] elem_value;
		logic signed [FIELD_W-1:0] vec_x;
		logic signed [FIELD_W-1:0] vec_y;
		logic signed [FIELD_W-1:0] vec_z;
		logic signed [FIELD_W-1:0] vec_w;
	} item_t;

	// One result item
	typedef struct packed {
		logic signed [FIELD_W-1:0] out_x;
		logic signed [FIELD_W-1:0] out_y;
		logic signed [FIELD_W-1:0] out_z;
		logic signed [FIELD_W-1:0] out_w;
		logic                      saturated;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mvt_mat_store.sv =====
// Matrix element register file: 16 elements, one written per load transfer.
// Depends on mvt_pkg for the matrix depth and index width.
`default_nettype none

module mvt_mat_store
	import mvt_pkg::*;
#(
	parameter int ELEM_W = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [IDX_W-1:0]                  wr_idx,
	input  wire logic [ELEM_W-1:0]                 wr_data,
	output logic      [MAT_DEPTH-1:0][ELEM_W-1:0]  mat
);

	logic [MAT_DEPTH-1:0][ELEM_W-1:0] mat_q;

	// Clear on reset, write one element per load transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (wr_en) begin
			mat_q[wr_idx] <= wr_data;
		end
	end

	assign mat = mat_q;

endmodule

`default_nettype wire

// ===== rtl/core/mvt_dot_lane.sv =====
// One output lane: four products, two-level add tree, shift and saturate.
// Depends on mvt_pkg for the lane count and field width.
`default_nettype none

module mvt_dot_lane
	import mvt_pkg::*;
#(
	parameter int ELEM_W = 32,
	parameter int FRAC_W = 16
) (
	input  wire logic                          clk,
	input  wire logic                          adv,
	input  wire logic [LANES-1:0][ELEM_W-1:0]  row,
	input  wire logic [LANES-1:0][ELEM_W-1:0]  vec,
	output logic      [FIELD_W-1:0]            res,
	output logic                               sat
);

	localparam int PROD_W = 2 * ELEM_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	// Largest and smallest element values at the sum width
	localparam logic signed [SUM_W-1:0] MAXV =
		{{(SUM_W - ELEM_W + 1){1'b0}}, {(ELEM_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] MINV = ~MAXV;

	logic signed [PROD_W-1:0] prod_c  [LANES];
	logic signed [PROD_W-1:0] prod_s2 [LANES];
	logic signed [PAIR_W-1:0] pair_s3 [2];
	logic signed [SUM_W-1:0]  sum_s4;
	logic signed [SUM_W-1:0]  shifted;
	logic signed [SUM_W-1:0]  clamped;
	logic                     sat_c;
	logic signed [ELEM_W-1:0] res_el;
	logic [FIELD_W-1:0]       res_s5;
	logic                     sat_s5;

	// Form the four element-by-component products
	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			prod_c[c] = signed'(row[c]) * signed'(vec[c]);
		end
	end

	// Arithmetic shift of the exact sum, then clamp to the element range
	always_comb begin
		shifted = sum_s4 >>> FRAC_W;
		sat_c   = 1'b0;
		clamped = shifted;
		if (shifted > MAXV) begin
			clamped = MAXV;
			sat_c   = 1'b1;
		end else if (shifted < MINV) begin
			clamped = MINV;
			sat_c   = 1'b1;
		end
		res_el = clamped[ELEM_W-1:0];
	end

	// Advance every stage together; hold on stall
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < LANES; c++) begin
				prod_s2[c] <= prod_c[c];
			end
			pair_s3[0] <= PAIR_W'(prod_s2[0]) + PAIR_W'(prod_s2[1]);
			pair_s3[1] <= PAIR_W'(prod_s2[2]) + PAIR_W'(prod_s2[3]);
			sum_s4     <= SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]);
			res_s5     <= FIELD_W'(res_el);
			sat_s5     <= sat_c;
		end
	end

	assign res = res_s5;
	assign sat = sat_s5;

endmodule

`default_nettype wire

// ===== rtl/core/matrix4_vector_transform_core.sv =====
// 4x4 matrix times 4-vector transform core, signed Q16.16.
//
// Usage: items arrive on the item channel (item_valid / item_stall / item).
// A load item (cmd = CMD_LOAD) writes one matrix element at elem_index
// (column * 4 + row) and gives no result. A transform item (cmd = CMD_XFORM)
// gives one result on the result channel: each lane is the dot product of a
// matrix row with the vector, shifted right by FRAC_BITS and saturated, with
// the saturated flag set when any lane was clamped. Stream the columns of a
// right-hand matrix to form a matrix product.
// Throughput: one item per cycle unless a valid result is stalled, loads and
// transforms mixed freely; a transform sees every load accepted before it.
// The pipeline is a 32x32 multiplier stage, two add stages and a
// shift/saturate stage per lane.
// Reset: the matrix clears to zeros and the pipeline empties.
// Stall: when a valid result is stalled the whole pipeline holds and
// item_stall rises in the same cycle; nothing is lost or repeated.
`default_nettype none

module matrix4_vector_transform_core
	import mvt_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	// Held and produced values are limited to the field width
	localparam int EW = (ELEM_WIDTH < FIELD_W) ? ELEM_WIDTH : FIELD_W;
	localparam logic [FIELD_W-1:0] LANE_MAX = FIELD_W'((64'd1 << (EW - 1)) - 64'd1);
	localparam logic [FIELD_W-1:0] LANE_MIN = ~LANE_MAX;

	logic                               adv;
	logic                               item_xfer;
	logic                               load_en;
	logic [MAT_DEPTH-1:0][EW-1:0]       mat;
	logic [LANES-1:0][LANES-1:0][EW-1:0] lane_row;
	logic [LANES-1:0][EW-1:0]           vec_s1;
	logic                               valid_s1;
	logic                               valid_s2;
	logic                               valid_s3;
	logic                               valid_s4;
	logic                               valid_s5;
	logic [LANES-1:0][FIELD_W-1:0]      lane_res;
	logic [LANES-1:0]                   lane_sat;

	// Whole pipeline advances unless a finished result is stalled
	assign adv        = !valid_s5 || !result_stall;
	assign item_stall = !adv;
	assign item_xfer  = item_valid && adv;
	assign load_en    = item_xfer && (item.cmd == CMD_LOAD);

	mvt_mat_store #(
		.ELEM_W (EW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_en),
		.wr_idx  (item.elem_index),
		.wr_data (item.elem_value[EW-1:0]),
		.mat     (mat)
	);

	// Capture the vector of a transform transfer
	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s1[0] <= item.vec_x[EW-1:0];
			vec_s1[1] <= item.vec_y[EW-1:0];
			vec_s1[2] <= item.vec_z[EW-1:0];
			vec_s1[3] <= item.vec_w[EW-1:0];
		end
	end

	// Carry valid bits alongside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid && (item.cmd == CMD_XFORM);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Pick row r of the column-major matrix for each lane
	for (genvar r = 0; r < LANES; r++) begin : g_lane
		for (genvar c = 0; c < LANES; c++) begin : g_col
			assign lane_row[r][c] = mat[c*LANES + r];
		end

		mvt_dot_lane #(
			.ELEM_W (EW),
			.FRAC_W (FRAC_BITS)
		) u_lane (
			.clk (clk),
			.adv (adv),
			.row (lane_row[r]),
			.vec (vec_s1),
			.res (lane_res[r]),
			.sat (lane_sat[r])
		);
	end

	// Assemble the result item
	assign result_valid     = valid_s5;
	assign result.out_x     = lane_res[0];
	assign result.out_y     = lane_res[1];
	assign result.out_z     = lane_res[2];
	assign result.out_w     = lane_res[3];
	assign result.saturated = |lane_sat;

`ifndef SYNTHESIS
	// A load transfer lands in the addressed element by the next edge
	a_load_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load_en |=> mat[$past(item.elem_index)] == $past(item.elem_value[EW-1:0]))
		else $error("matrix element not written by load transfer");

	// A flagged result carries at least one clamped lane
	a_sat_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && result.saturated) |->
			(lane_res[0] == LANE_MAX || lane_res[0] == LANE_MIN ||
			 lane_res[1] == LANE_MAX || lane_res[1] == LANE_MIN ||
			 lane_res[2] == LANE_MAX || lane_res[2] == LANE_MIN ||
			 lane_res[3] == LANE_MAX || lane_res[3] == LANE_MIN))
		else $error("saturated flag without a clamped lane");

	// A transform in the first stage moves on when the pipeline advances
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv) |=> valid_s2)
		else $error("transform dropped between stages");

	// A taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && !result_stall && !valid_s4) |=> !valid_s5)
		else $error("result repeated after transfer");
`endif

endmodule

`default_nettype wire

// ===== test/matrix4_vector_transform_core_tb.sv =====
// Self-checking testbench for matrix4_vector_transform_core: loads and transforms go through a
// directed table, then a random stream, each result checked against a table or predictor value.
// Depends on mvt_pkg and the core RTL only.
`default_nettype none

module matrix4_vector_transform_core_tb;
	import mvt_pkg::*;

	localparam int FRAC         = 16;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1250;
	localparam int LONG_HOLD    = 120;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SCALED_W     = 2 * FIELD_W + 2 - FRAC;

	localparam logic signed [FIELD_W-1:0] ELEM_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] ELEM_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
	localparam logic signed [FIELD_W-1:0] Q_ONE    = 1 << FRAC;

	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	logic signed [FIELD_W-1:0] mat_shadow [MAT_DEPTH];
	result_t   pending_results [$];
	stim_row_t stim_table [$];
	result_t   oldest;
	int        error_count    = 0;
	int        accepted_count = 0;
	int        burst_left     = 0;
	int        cycle_count    = 0;
	bit        hold_done      = 1'b0;

	matrix4_vector_transform_core #(
		.FRAC_BITS  (FRAC),
		.ELEM_WIDTH (FIELD_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected lanes: exact dot of each row with the vector, floor-shifted, clamped
	function automatic result_t matrix_times_vector(input item_t stim);
		logic signed [FIELD_W-1:0]   comp [LANES];
		logic signed [FIELD_W-1:0]   lane_out [LANES];
		logic signed [2*FIELD_W-1:0] prod;
		logic signed [2*FIELD_W+1:0] acc;
		logic signed [SCALED_W-1:0]  scaled;
		logic                        clamped;
		comp[0] = stim.vec_x;
		comp[1] = stim.vec_y;
		comp[2] = stim.vec_z;
		comp[3] = stim.vec_w;
		clamped = 1'b0;
		for (int row = 0; row < LANES; row++) begin
			acc = '0;
			for (int col = 0; col < LANES; col++) begin
				prod = mat_shadow[col * LANES + row] * comp[col];
				acc = acc + prod;
			end
			scaled = acc >>> FRAC;
			if (scaled > ELEM_MAX) begin
				lane_out[row] = ELEM_MAX;
				clamped = 1'b1;
			end else if (scaled < ELEM_MIN) begin
				lane_out[row] = ELEM_MIN;
				clamped = 1'b1;
			end else begin
				lane_out[row] = scaled[FIELD_W-1:0];
			end
		end
		return '{lane_out[0], lane_out[1], lane_out[2], lane_out[3], clamped};
	endfunction

	function automatic result_t lanes(input logic signed [FIELD_W-1:0] x, y, z, w,
			input logic sat);
		return '{x, y, z, w, sat};
	endfunction

	// Vector fields carry noise on a load, they must be ignored
	function automatic item_t load_item(input logic [IDX_W-1:0] idx,
			input logic signed [FIELD_W-1:0] val);
		item_t stim;
		stim.cmd        = CMD_LOAD;
		stim.elem_index = idx;
		stim.elem_value = val;
		stim.vec_x      = $urandom;
		stim.vec_y      = $urandom;
		stim.vec_z      = $urandom;
		stim.vec_w      = $urandom;
		return stim;
	endfunction

	// Element fields carry noise on a transform, they must be ignored
	function automatic item_t xform_item(input logic signed [FIELD_W-1:0] x, y, z, w);
		item_t stim;
		stim.cmd        = CMD_XFORM;
		stim.elem_index = IDX_W'($urandom_range(0, MAT_DEPTH - 1));
		stim.elem_value = $urandom;
		stim.vec_x      = x;
		stim.vec_y      = y;
		stim.vec_z      = z;
		stim.vec_w      = w;
		return stim;
	endfunction

	// Small fixed-point values most often, so lanes stay in range; some extremes and full range
	function automatic logic signed [FIELD_W-1:0] pick_fixed();
		case ($urandom_range(0, 11))
			0:       return ELEM_MAX;
			1:       return ELEM_MIN;
			2:       return '0;
			3:       return -1;
			4, 5, 6: return $urandom;
			default: return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
		endcase
	endfunction

	task automatic add_row(input item_t stim, input logic typed, input result_t want);
		stim_table.push_back('{stim, typed, want});
	endtask

	// Offer one item in bursts with random gaps; update the shadow matrix on transfer
	task automatic offer_item(input item_t stim, input logic typed, input result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item       <= stim;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (stim.cmd == CMD_LOAD)
			mat_shadow[stim.elem_index] = stim.elem_value;
		else
			pending_results.push_back(typed ? want : matrix_times_vector(stim));
		accepted_count++;
	endtask

	task automatic compare_field(input string field, input logic [FIELD_W-1:0] want, got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, got 0x%08h", field, want, got);
			error_count++;
		end
	endtask

	// Stimulus: reset, directed table, random stream, drain
	initial begin
		int n;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		foreach (mat_shadow[i]) mat_shadow[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cleared matrix gives zeros whatever the vector
		add_row(xform_item(ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MIN), 1'b1,
			lanes(0, 0, 0, 0, 1'b0));
		// identity passes the vector through, extremes included
		add_row(load_item(0, Q_ONE), 1'b0, '0);
		add_row(load_item(5, Q_ONE), 1'b0, '0);
		add_row(load_item(10, Q_ONE), 1'b0, '0);
		add_row(load_item(15, Q_ONE), 1'b0, '0);
		add_row(xform_item(Q_ONE, 2 * Q_ONE, -3 * Q_ONE, 4 * Q_ONE), 1'b1,
			lanes(Q_ONE, 2 * Q_ONE, -3 * Q_ONE, 4 * Q_ONE, 1'b0));
		add_row(xform_item(ELEM_MAX, ELEM_MIN, -1, 1), 1'b1,
			lanes(ELEM_MAX, ELEM_MIN, -1, 1, 1'b0));
		// clamp high and low on one lane
		add_row(load_item(0, ELEM_MAX), 1'b0, '0);
		add_row(xform_item(ELEM_MAX, 0, 0, 0), 1'b1, lanes(ELEM_MAX, 0, 0, 0, 1'b1));
		add_row(xform_item(ELEM_MIN, 0, 0, 0), 1'b1, lanes(ELEM_MIN, 0, 0, 0, 1'b1));
		add_row(load_item(0, ELEM_MIN), 1'b0, '0);
		add_row(xform_item(ELEM_MIN, 0, 0, 0), 1'b1, lanes(ELEM_MAX, 0, 0, 0, 1'b1));
		// tiny negative product rounds toward minus infinity
		add_row(load_item(0, 1), 1'b0, '0);
		add_row(xform_item(-1, 0, 0, 0), 1'b0, '0);
		// sum of three largest products overflows 64 bits
		add_row(load_item(4, ELEM_MIN), 1'b0, '0);
		add_row(load_item(8, ELEM_MIN), 1'b0, '0);
		add_row(load_item(12, ELEM_MIN), 1'b0, '0);
		add_row(xform_item(0, ELEM_MIN, ELEM_MIN, ELEM_MIN), 1'b1,
			lanes(ELEM_MAX, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1));
		add_row(xform_item(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX), 1'b1,
			lanes(ELEM_MIN, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1));
		// mixed signs and fractions
		add_row(load_item(3, -Q_ONE), 1'b0, '0);
		add_row(load_item(9, 32'sh0000_8000), 1'b0, '0);
		add_row(xform_item(Q_ONE, -Q_ONE, ELEM_MAX, 3), 1'b0, '0);
		add_row(xform_item(pick_fixed(), pick_fixed(), pick_fixed(), pick_fixed()), 1'b0, '0);

		foreach (stim_table[i])
			offer_item(stim_table[i].stim, stim_table[i].typed, stim_table[i].want);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				// reload the whole matrix, then stream four columns through it
				for (int k = 0; k < MAT_DEPTH; k++)
					offer_item(load_item(IDX_W'(k), pick_fixed()), 1'b0, '0);
				for (int k = 0; k < LANES; k++)
					offer_item(xform_item(pick_fixed(), pick_fixed(), pick_fixed(),
						pick_fixed()), 1'b0, '0);
				n += MAT_DEPTH + LANES;
			end else begin
				if ($urandom_range(0, 2) == 0)
					offer_item(load_item(IDX_W'($urandom_range(0, MAT_DEPTH - 1)),
						pick_fixed()), 1'b0, '0);
				else
					offer_item(xform_item(pick_fixed(), pick_fixed(), pick_fixed(),
						pick_fixed()), 1'b0, '0);
				n++;
			end
		end
		item_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver stall pattern: calm, light, heavy, toggling and full-span holds
	initial begin
		int span;
		int mode;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			// one long hold while items keep coming, so the core backs up
			if (!hold_done && accepted_count >= 400) begin
				hold_done = 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					result_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 4);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0:       result_stall <= 1'b0;
					1:       result_stall <= ($urandom_range(0, 3) == 0);
					2:       result_stall <= ($urandom_range(0, 3) != 0);
					3:       result_stall <= ~result_stall;
					default: result_stall <= 1'b1;
				endcase
			end
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing pending: 0x%h", result);
				error_count++;
			end else begin
				oldest = pending_results.pop_front();
				compare_field("out_x", oldest.out_x, result.out_x);
				compare_field("out_y", oldest.out_y, result.out_y);
				compare_field("out_z", oldest.out_z, result.out_z);
				compare_field("out_w", oldest.out_w, result.out_w);
				compare_field("saturated", oldest.saturated, result.saturated);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/mvt_pkg.sv
rtl/core/mvt_mat_store.sv
rtl/core/mvt_dot_lane.sv
rtl/core/matrix4_vector_transform_core.sv
test/matrix4_vector_transform_core_tb.sv
